>>> rtl/core/hhcm_pkg.sv
// Shared types, register codes and constant tables of the memory map unit.
// Used by every module in rtl/core but hhcm_ram; it depends on nothing else.
`timescale 1ns / 1ps

package hhcm_pkg;

    localparam int IDX_W        = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 4;
    localparam int VIDEO_RAM_BYTES_DEF    = 16384;
    localparam int WORK_RAM_BYTES_DEF     = 36864;
    localparam int SPRITE_TABLE_BYTES_DEF = 160;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_BANK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORK_BANK  = 1'd1;

    typedef enum logic [2:0] {
        ROUTE_INTERNAL = 3'd0,
        ROUTE_CART     = 3'd1,
        ROUTE_CART_RAM = 3'd2,
        ROUTE_AUDIO    = 3'd3,
        ROUTE_DROP     = 3'd4
    } t_route;

    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_BOOT = 3'd1,
        TGT_VRAM = 3'd2,
        TGT_WRAM = 3'd3,
        TGT_OAM  = 3'd4,
        TGT_HIGH = 3'd5
    } t_tgt;

    // High page register offsets.
    localparam logic [7:0] REG_JOYP    = 8'h00;
    localparam logic [7:0] REG_SC      = 8'h02;
    localparam logic [7:0] REG_DIV     = 8'h04;
    localparam logic [7:0] REG_TAC     = 8'h07;
    localparam logic [7:0] REG_IF      = 8'h0F;
    localparam logic [7:0] REG_AUD_LO  = 8'h10;
    localparam logic [7:0] REG_AUD_HI  = 8'h3F;
    localparam logic [7:0] REG_STAT    = 8'h41;
    localparam logic [7:0] REG_DMA     = 8'h46;
    localparam logic [7:0] REG_KEY1    = 8'h4D;
    localparam logic [7:0] REG_VBK     = 8'h4F;
    localparam logic [7:0] REG_BOOT    = 8'h50;
    localparam logic [7:0] REG_HDMA5   = 8'h55;
    localparam logic [7:0] REG_PAL_LO  = 8'h68;
    localparam logic [7:0] REG_PAL_HI  = 8'h6B;
    localparam logic [7:0] REG_SVBK    = 8'h70;
    localparam logic [7:0] REG_GAP_LO  = 8'h73;
    localparam logic [7:0] REG_GAP_HI  = 8'h77;

    localparam logic [7:0] JOYP_SET  = 8'hC0;
    localparam logic [7:0] IF_SET    = 8'hE0;
    localparam logic [7:0] TAC_SET   = 8'hF8;
    localparam logic [7:0] STAT_SET  = 8'h80;

    // One bus access after classification, waiting for the back end.
    typedef struct packed {
        logic             wr;
        t_tgt             tgt;
        t_route           route;
        logic [IDX_W-1:0] idx;
        logic [7:0]       wdata;
        logic [7:0]       buttons;
    } t_cmd;

    // One finished result.
    typedef struct packed {
        logic [7:0] read_data;
        t_route     route;
        logic       divider_reset;
        logic       timer_phase_reset;
        logic       dma_request;
        logic [7:0] dma_source_page;
    } t_res;

    // Offset of work RAM bank b at 0xD000, wrapped into a store of w bytes.
    function automatic logic [16:0] wram_bank_base(input int b, input int w);
        int v;
        v = (b + 1) * 4096;
        for (int k = 0; k < 17; k++) begin
            if (v >= w) begin
                v = v - w;
            end
        end
        return 17'(v);
    endfunction

    // Power-on value of a high page register.
    function automatic logic [7:0] high_default(input logic [7:0] a);
        logic [7:0] v;
        case (a)
            8'h04: v = 8'h1E;
            8'h07: v = 8'hF8;
            8'h0F: v = 8'hE1;
            8'h10: v = 8'h80;
            8'h11: v = 8'hBF;
            8'h12: v = 8'hF3;
            8'h14: v = 8'hBF;
            8'h16: v = 8'h3F;
            8'h19: v = 8'hBF;
            8'h1A: v = 8'h7F;
            8'h1B: v = 8'hFF;
            8'h1C: v = 8'h9F;
            8'h1E: v = 8'hBF;
            8'h20: v = 8'hFF;
            8'h23: v = 8'hBF;
            8'h24: v = 8'h77;
            8'h25: v = 8'hF3;
            8'h26: v = 8'hF1;
            8'h40: v = 8'h91;
            8'h41: v = 8'h85;
            8'h47: v = 8'hFC;
            8'h48: v = 8'hFF;
            8'h49: v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    localparam logic [7:0] BOOT_ROM [256] = '{
        8'h31, 8'hFE, 8'hFF, 8'hAF, 8'h21, 8'hFF, 8'h9F, 8'h32,
        8'hCB, 8'h7C, 8'h20, 8'hFB, 8'h21, 8'h26, 8'hFF, 8'h0E,
        8'h11, 8'h3E, 8'h80, 8'h32, 8'hE2, 8'h0C, 8'h3E, 8'hF3,
        8'hE2, 8'h32, 8'h3E, 8'h77, 8'h77, 8'h3E, 8'hFC, 8'hE0,
        8'h47, 8'h11, 8'h04, 8'h01, 8'h21, 8'h10, 8'h80, 8'h1A,
        8'hCD, 8'h95, 8'h00, 8'hCD, 8'h96, 8'h00, 8'h13, 8'h7B,
        8'hFE, 8'h34, 8'h20, 8'hF3, 8'h11, 8'hD8, 8'h00, 8'h06,
        8'h08, 8'h1A, 8'h13, 8'h22, 8'h23, 8'h05, 8'h20, 8'hF9,
        8'h3E, 8'h19, 8'hEA, 8'h10, 8'h99, 8'h21, 8'h2F, 8'h99,
        8'h0E, 8'h0C, 8'h3D, 8'h28, 8'h08, 8'h32, 8'h0D, 8'h20,
        8'hF9, 8'h2E, 8'h0F, 8'h18, 8'hF3, 8'h67, 8'h3E, 8'h64,
        8'h57, 8'hE0, 8'h42, 8'h3E, 8'h91, 8'hE0, 8'h40, 8'h04,
        8'h1E, 8'h02, 8'h0E, 8'h0C, 8'hF0, 8'h44, 8'hFE, 8'h90,
        8'h20, 8'hFA, 8'h0D, 8'h20, 8'hF7, 8'h1D, 8'h20, 8'hF2,
        8'h0E, 8'h13, 8'h24, 8'h7C, 8'h1E, 8'h83, 8'hFE, 8'h62,
        8'h28, 8'h06, 8'h1E, 8'hC1, 8'hFE, 8'h64, 8'h20, 8'h06,
        8'h7B, 8'hE2, 8'h0C, 8'h3E, 8'h87, 8'hF2, 8'hF0, 8'h42,
        8'h90, 8'hE0, 8'h42, 8'h15, 8'h20, 8'hD2, 8'h05, 8'h20,
        8'h4F, 8'h16, 8'h20, 8'h18, 8'hCB, 8'h4F, 8'h06, 8'h04,
        8'hC5, 8'hCB, 8'h11, 8'h17, 8'hC1, 8'hCB, 8'h11, 8'h17,
        8'h05, 8'h20, 8'hF5, 8'h22, 8'h23, 8'h22, 8'h23, 8'hC9,
        8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
        8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
        8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
        8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
        8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E,
        8'h3C, 8'h42, 8'hB9, 8'hA5, 8'hB9, 8'hA5, 8'h42, 8'h4C,
        8'h21, 8'h04, 8'h01, 8'h11, 8'hA8, 8'h00, 8'h1A, 8'h13,
        8'hBE, 8'h20, 8'hFE, 8'h23, 8'h7D, 8'hFE, 8'h34, 8'h20,
        8'hF5, 8'h06, 8'h19, 8'h78, 8'h86, 8'h23, 8'h05, 8'h20,
        8'hFB, 8'h86, 8'h20, 8'hFE, 8'h3E, 8'h01, 8'hE0, 8'h50
    };

endpackage

>>> rtl/core/hhcm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package is used.
`timescale 1ns / 1ps

module hhcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/hhcm_front.sv
// Front end: accepts bus accesses, decodes the address map, computes the
// store index and queues the command. Depends on hhcm_pkg.
`timescale 1ns / 1ps

module hhcm_front #(
    parameter int VIDEO_RAM_BYTES    = hhcm_pkg::VIDEO_RAM_BYTES_DEF,
    parameter int WORK_RAM_BYTES     = hhcm_pkg::WORK_RAM_BYTES_DEF,
    parameter int SPRITE_TABLE_BYTES = hhcm_pkg::SPRITE_TABLE_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_hold,
    input  logic            i_push,
    output logic            o_full,
    input  logic            i_operation,
    input  logic [15:0]     i_address,
    input  logic [7:0]      i_write_data,
    input  logic [7:0]      i_button_mask,
    input  logic            i_video_bank,
    input  logic [3:0]      i_work_bank,
    output logic            o_cmd_valid,
    output hhcm_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_pop
);

    localparam logic [16:0] OAM_END = 17'(32'hFE00 + SPRITE_TABLE_BYTES);

    hhcm_pkg::t_cmd r_q [2];
    logic           r_rd;
    logic           r_wp;
    logic [1:0]     r_cnt;
    hhcm_pkg::t_cmd c;
    logic           accept;

    logic [16:0] base_tab [16];
    logic [14:0] v_off;
    logic [14:0] v_idx;
    logic [16:0] w_off;
    logic [16:0] w_idx;

    for (genvar g = 0; g < 16; g++) begin : g_base
        assign base_tab[g] = hhcm_pkg::wram_bank_base(g, WORK_RAM_BYTES);
    end

    always_comb begin
        v_off = {2'b00, i_address[12:0]} + (i_video_bank ? 15'h2000 : 15'h0000);
        v_idx = (v_off >= 15'(VIDEO_RAM_BYTES)) ? v_off - 15'(VIDEO_RAM_BYTES) : v_off;
        w_off = base_tab[i_work_bank] + {5'b00000, i_address[11:0]};
        w_idx = (w_off >= 17'(WORK_RAM_BYTES)) ? w_off - 17'(WORK_RAM_BYTES) : w_off;
    end

    always_comb begin
        c.wr      = i_operation;
        c.tgt     = hhcm_pkg::TGT_NONE;
        c.route   = hhcm_pkg::ROUTE_INTERNAL;
        c.idx     = '0;
        c.wdata   = i_write_data;
        c.buttons = i_button_mask;
        if (i_address < 16'h0100) begin
            if (i_operation) begin
                c.route = hhcm_pkg::ROUTE_DROP;
            end else begin
                c.tgt = hhcm_pkg::TGT_BOOT;
                c.idx = {8'h00, i_address[7:0]};
            end
        end else if (i_address < 16'h8000) begin
            c.route = hhcm_pkg::ROUTE_CART;
        end else if (i_address < 16'hA000) begin
            c.tgt = hhcm_pkg::TGT_VRAM;
            c.idx = {1'b0, v_idx};
        end else if (i_address < 16'hC000) begin
            c.route = i_operation ? hhcm_pkg::ROUTE_CART_RAM : hhcm_pkg::ROUTE_CART;
        end else if (i_address < 16'hD000) begin
            c.tgt = hhcm_pkg::TGT_WRAM;
            c.idx = {4'h0, i_address[11:0]};
        end else if (i_address < 16'hE000) begin
            c.tgt = hhcm_pkg::TGT_WRAM;
            c.idx = w_idx[15:0];
        end else if (i_address < 16'hFE00) begin
            // Echo area: readable mirror of the low work RAM, writes dropped.
            if (i_operation) begin
                c.route = hhcm_pkg::ROUTE_DROP;
            end else begin
                c.tgt = hhcm_pkg::TGT_WRAM;
                c.idx = i_address - 16'hE000;
            end
        end else if ({1'b0, i_address} < OAM_END) begin
            c.tgt = hhcm_pkg::TGT_OAM;
            c.idx = {8'h00, i_address[7:0]};
        end else if (i_address < 16'hFF00) begin
            if (i_operation) begin
                c.route = hhcm_pkg::ROUTE_DROP;
            end
        end else begin
            c.tgt = hhcm_pkg::TGT_HIGH;
            c.idx = {8'h00, i_address[7:0]};
        end
    end

    assign o_full      = (r_cnt == 2'd2) || i_hold;
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, accept} - {1'b0, i_cmd_pop};
        end
        if (accept) begin
            r_q[r_wp] <= c;
        end
    end

endmodule

>>> rtl/core/hhcm_back.sv
// Back end: clears the stores after reset, carries out queued commands on
// the memories and the high page, and queues results. Depends on hhcm_pkg
// and hhcm_ram.
`timescale 1ns / 1ps

module hhcm_back #(
    parameter int VIDEO_RAM_BYTES    = hhcm_pkg::VIDEO_RAM_BYTES_DEF,
    parameter int WORK_RAM_BYTES     = hhcm_pkg::WORK_RAM_BYTES_DEF,
    parameter int SPRITE_TABLE_BYTES = hhcm_pkg::SPRITE_TABLE_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    output logic            o_clearing,
    input  logic            i_cmd_valid,
    input  hhcm_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    input  logic            i_video_bank,
    input  logic [3:0]      i_work_bank,
    output logic            o_res_valid,
    output hhcm_pkg::t_res  o_res,
    input  logic            i_res_pop
);

    localparam int VW    = $clog2(VIDEO_RAM_BYTES);
    localparam int WW    = $clog2(WORK_RAM_BYTES);
    localparam int OW    = $clog2(SPRITE_TABLE_BYTES);
    localparam int CLR_N = (VIDEO_RAM_BYTES > WORK_RAM_BYTES) ? VIDEO_RAM_BYTES
                                                               : WORK_RAM_BYTES;
    localparam int CW    = $clog2(CLR_N);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ} t_state;

    t_state         r_state;
    logic [CW-1:0]  r_clr;
    hhcm_pkg::t_cmd r_cmd;
    logic           r_boot_off;
    logic [1:0]     r_tac_lo;
    hhcm_pkg::t_res r_oq [2];
    logic           r_orp;
    logic           r_owp;
    logic [1:0]     r_ocnt;

    logic           pop;
    logic           push;
    hhcm_pkg::t_res res_n;
    hhcm_pkg::t_res wres;
    hhcm_pkg::t_res rres;
    logic           hp_store;
    logic [7:0]     hp_wval;
    logic [7:0]     reg_w;
    logic [7:0]     reg_r;

    logic          v_we, w_we, o_we, h_we;
    logic [VW-1:0] v_wa;
    logic [WW-1:0] w_wa;
    logic [OW-1:0] o_wa;
    logic [7:0]    h_wa;
    logic [7:0]    v_wd, w_wd, o_wd, h_wd;
    logic [7:0]    v_rd, w_rd, o_rd, h_rd;

    assign o_clearing  = (r_state == S_CLEAR);
    assign pop         = (r_state == S_IDLE) && i_cmd_valid && (r_ocnt != 2'd2);
    assign o_cmd_pop   = pop;
    assign o_res_valid = (r_ocnt != 2'd0);
    assign o_res       = r_oq[r_orp];
    assign reg_w       = i_cmd.idx[7:0];
    assign reg_r       = r_cmd.idx[7:0];

    // Side effects and result of a write to the high page.
    always_comb begin
        wres          = '0;
        wres.route    = i_cmd.route;
        hp_store      = 1'b0;
        hp_wval       = i_cmd.wdata;
        if (i_cmd.tgt == hhcm_pkg::TGT_HIGH) begin
            unique case (reg_w) inside
                [hhcm_pkg::REG_AUD_LO:hhcm_pkg::REG_AUD_HI]: begin
                    hp_store   = 1'b1;
                    wres.route = hhcm_pkg::ROUTE_AUDIO;
                end
                hhcm_pkg::REG_DIV: begin
                    hp_store           = 1'b1;
                    hp_wval            = 8'h00;
                    wres.divider_reset = 1'b1;
                end
                hhcm_pkg::REG_TAC: begin
                    hp_store               = 1'b1;
                    hp_wval                = i_cmd.wdata | hhcm_pkg::TAC_SET;
                    wres.timer_phase_reset = (r_tac_lo != i_cmd.wdata[1:0]);
                end
                hhcm_pkg::REG_STAT: begin
                    hp_store = 1'b1;
                    hp_wval  = i_cmd.wdata | hhcm_pkg::STAT_SET;
                end
                hhcm_pkg::REG_DMA: begin
                    wres.dma_request     = 1'b1;
                    wres.dma_source_page = i_cmd.wdata;
                end
                hhcm_pkg::REG_SC, hhcm_pkg::REG_KEY1, hhcm_pkg::REG_VBK,
                hhcm_pkg::REG_HDMA5, [hhcm_pkg::REG_PAL_LO:hhcm_pkg::REG_PAL_HI],
                hhcm_pkg::REG_SVBK: begin
                    wres.route = hhcm_pkg::ROUTE_DROP;
                end
                default: begin
                    hp_store = 1'b1;
                end
            endcase
        end
    end

    // Result of a read, in the cycle after the memories were addressed.
    always_comb begin
        rres       = '0;
        rres.route = r_cmd.route;
        unique case (r_cmd.tgt)
            hhcm_pkg::TGT_BOOT: begin
                if (r_boot_off) begin
                    rres.route = hhcm_pkg::ROUTE_CART;
                end else begin
                    rres.read_data = hhcm_pkg::BOOT_ROM[reg_r];
                end
            end
            hhcm_pkg::TGT_VRAM: rres.read_data = v_rd;
            hhcm_pkg::TGT_WRAM: rres.read_data = w_rd;
            hhcm_pkg::TGT_OAM:  rres.read_data = o_rd;
            hhcm_pkg::TGT_HIGH: begin
                unique case (reg_r) inside
                    hhcm_pkg::REG_JOYP: begin
                        // Column select: bit 4 picks the low button group,
                        // else bit 5 the high group, else nothing pressed.
                        rres.read_data = h_rd | hhcm_pkg::JOYP_SET;
                        if (h_rd[4]) begin
                            rres.read_data[3:0] = rres.read_data[3:0]
                                                | r_cmd.buttons[3:0];
                        end else if (h_rd[5]) begin
                            rres.read_data[3:0] = rres.read_data[3:0]
                                                | r_cmd.buttons[7:4];
                        end else begin
                            rres.read_data[3:0] = 4'hF;
                        end
                    end
                    [hhcm_pkg::REG_AUD_LO:hhcm_pkg::REG_AUD_HI]: begin
                        rres.route = hhcm_pkg::ROUTE_AUDIO;
                    end
                    hhcm_pkg::REG_IF: rres.read_data = h_rd | hhcm_pkg::IF_SET;
                    [hhcm_pkg::REG_GAP_LO:hhcm_pkg::REG_GAP_HI],
                    [hhcm_pkg::REG_PAL_LO:hhcm_pkg::REG_PAL_HI],
                    hhcm_pkg::REG_KEY1: rres.read_data = 8'h00;
                    hhcm_pkg::REG_VBK:  rres.read_data = {7'd0, i_video_bank};
                    hhcm_pkg::REG_SVBK: rres.read_data = {4'd0, i_work_bank};
                    default:            rres.read_data = h_rd;
                endcase
            end
            default: ;
        endcase
    end

    // Memory write ports: the clearing pass, else the popped write.
    always_comb begin
        v_we = 1'b0;
        w_we = 1'b0;
        o_we = 1'b0;
        h_we = 1'b0;
        v_wa = i_cmd.idx[VW-1:0];
        w_wa = i_cmd.idx[WW-1:0];
        o_wa = i_cmd.idx[OW-1:0];
        h_wa = reg_w;
        v_wd = i_cmd.wdata;
        w_wd = i_cmd.wdata;
        o_wd = i_cmd.wdata;
        h_wd = hp_wval;
        if (r_state == S_CLEAR) begin
            v_we = ({{(32-CW){1'b0}}, r_clr} < 32'(VIDEO_RAM_BYTES));
            w_we = ({{(32-CW){1'b0}}, r_clr} < 32'(WORK_RAM_BYTES));
            o_we = ({{(32-CW){1'b0}}, r_clr} < 32'(SPRITE_TABLE_BYTES));
            h_we = ({{(32-CW){1'b0}}, r_clr} < 32'd256);
            v_wa = r_clr[VW-1:0];
            w_wa = r_clr[WW-1:0];
            o_wa = r_clr[OW-1:0];
            h_wa = r_clr[7:0];
            v_wd = 8'h00;
            w_wd = 8'h00;
            o_wd = 8'h00;
            h_wd = hhcm_pkg::high_default(r_clr[7:0]);
        end else if (pop && i_cmd.wr) begin
            v_we = (i_cmd.tgt == hhcm_pkg::TGT_VRAM);
            w_we = (i_cmd.tgt == hhcm_pkg::TGT_WRAM);
            o_we = (i_cmd.tgt == hhcm_pkg::TGT_OAM);
            h_we = (i_cmd.tgt == hhcm_pkg::TGT_HIGH) && hp_store;
        end
    end

    hhcm_ram #(.WIDTH(8), .DEPTH(VIDEO_RAM_BYTES)) u_vram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(i_cmd.idx[VW-1:0]), .o_rdata(v_rd)
    );
    hhcm_ram #(.WIDTH(8), .DEPTH(WORK_RAM_BYTES)) u_wram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_wa), .i_wdata(w_wd),
        .i_raddr(i_cmd.idx[WW-1:0]), .o_rdata(w_rd)
    );
    hhcm_ram #(.WIDTH(8), .DEPTH(SPRITE_TABLE_BYTES)) u_oam (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_wa), .i_wdata(o_wd),
        .i_raddr(i_cmd.idx[OW-1:0]), .o_rdata(o_rd)
    );
    hhcm_ram #(.WIDTH(8), .DEPTH(256)) u_high (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(reg_w), .o_rdata(h_rd)
    );

    always_comb begin
        push  = 1'b0;
        res_n = rres;
        if (r_state == S_READ) begin
            push = 1'b1;
        end else if (pop && i_cmd.wr) begin
            push  = 1'b1;
            res_n = wres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_boot_off <= 1'b0;
            r_tac_lo   <= hhcm_pkg::TAC_SET[1:0];
            r_orp      <= 1'b0;
            r_owp      <= 1'b0;
            r_ocnt     <= 2'd0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CW'(CLR_N - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop && !i_cmd.wr) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_CLEAR;
            endcase
            if (pop && i_cmd.wr && h_we) begin
                if (reg_w == hhcm_pkg::REG_BOOT) begin
                    r_boot_off <= (i_cmd.wdata != 8'h00);
                end
                if (reg_w == hhcm_pkg::REG_TAC) begin
                    r_tac_lo <= i_cmd.wdata[1:0];
                end
            end
            if (push) begin
                r_owp <= ~r_owp;
            end
            if (i_res_pop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, push} - {1'b0, i_res_pop};
        end
        if (pop) begin
            r_cmd <= i_cmd;
        end
        if (push) begin
            r_oq[r_owp] <= res_n;
        end
    end

endmodule

>>> rtl/core/handheld_console_memory_map_unit.sv
// Top level of the console memory map unit: front end, back end and the
// bank configuration registers. Depends on hhcm_pkg, hhcm_front, hhcm_back.
`timescale 1ns / 1ps
//
//  Channel     Handshake               Payload
//  ---------   ---------------------   ----------------------------------------
//  Bus in      push / full             operation, address, write_data,
//                                      button_mask
//  Result out  empty / pop             read_data, route, divider_reset,
//                                      timer_phase_reset, dma_request,
//                                      dma_source_page
//  Config      cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  A write passes through the command queue and the result queue before its
//  result is visible, a read also through the registered read data of the
//  target memory. The back end takes one write per cycle while results are
//  popped, but takes no new command until a read's result is queued.
//  After reset a clearing pass zeroes video RAM, work RAM and the sprite
//  table and loads the high page defaults; full stays high meanwhile.
//  A two-word queue between the ends and another at the output let the bus
//  side keep pushing while results wait to be popped.

module handheld_console_memory_map_unit #(
    parameter int VIDEO_RAM_BYTES    = hhcm_pkg::VIDEO_RAM_BYTES_DEF,
    parameter int WORK_RAM_BYTES     = hhcm_pkg::WORK_RAM_BYTES_DEF,
    parameter int SPRITE_TABLE_BYTES = hhcm_pkg::SPRITE_TABLE_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_operation,
    input  logic [15:0]                       i_address,
    input  logic [7:0]                        i_write_data,
    input  logic [7:0]                        i_button_mask,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        o_read_data,
    output logic [2:0]                        o_route,
    output logic                              o_divider_reset,
    output logic                              o_timer_phase_reset,
    output logic                              o_dma_request,
    output logic [7:0]                        o_dma_source_page,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hhcm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hhcm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Bank selects. The user must change them only while the unit is idle, as
    // the front end folds them into the store index at decode time; unchecked.
    logic           r_video_bank;
    logic [3:0]     r_work_bank;

    logic           clearing;
    logic           cmd_valid;
    logic           cmd_pop;
    hhcm_pkg::t_cmd cmd;
    logic           res_valid;
    hhcm_pkg::t_res res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_bank <= 1'b0;
            r_work_bank  <= 4'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hhcm_pkg::CFG_VIDEO_BANK: r_video_bank <= i_cfg_data[0];
                hhcm_pkg::CFG_WORK_BANK:  r_work_bank  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hhcm_front #(
        .VIDEO_RAM_BYTES(VIDEO_RAM_BYTES),
        .WORK_RAM_BYTES(WORK_RAM_BYTES),
        .SPRITE_TABLE_BYTES(SPRITE_TABLE_BYTES)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_hold(clearing),
        .i_push(push),
        .o_full(full),
        .i_operation(i_operation),
        .i_address(i_address),
        .i_write_data(i_write_data),
        .i_button_mask(i_button_mask),
        .i_video_bank(r_video_bank),
        .i_work_bank(r_work_bank),
        .o_cmd_valid(cmd_valid),
        .o_cmd(cmd),
        .i_cmd_pop(cmd_pop)
    );

    hhcm_back #(
        .VIDEO_RAM_BYTES(VIDEO_RAM_BYTES),
        .WORK_RAM_BYTES(WORK_RAM_BYTES),
        .SPRITE_TABLE_BYTES(SPRITE_TABLE_BYTES)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .o_clearing(clearing),
        .i_cmd_valid(cmd_valid),
        .i_cmd(cmd),
        .o_cmd_pop(cmd_pop),
        .i_video_bank(r_video_bank),
        .i_work_bank(r_work_bank),
        .o_res_valid(res_valid),
        .o_res(res),
        .i_res_pop(pop && res_valid)
    );

    // The result queue head drives the ports directly.
    assign empty               = !res_valid;
    assign o_read_data         = res.read_data;
    assign o_route             = res.route;
    assign o_divider_reset     = res.divider_reset;
    assign o_timer_phase_reset = res.timer_phase_reset;
    assign o_dma_request       = res.dma_request;
    assign o_dma_source_page   = res.dma_source_page;

endmodule
